// ----- src/csvfs_pkg.sv -----
// ---------------------------------------------------------------------------
// csvfs_pkg
// Shared types and constants of the delimited-text field splitter.
// ---------------------------------------------------------------------------
package csvfs_pkg;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_SEPARATOR = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_QUOTE     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEADER    = 2'd2;

   localparam logic [7:0] SEPARATOR_RST = 8'd44;
   localparam logic [7:0] QUOTE_RST     = 8'd34;
   localparam logic [7:0] HEADER_RST    = 8'd0;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;
   localparam logic [7:0] POS_SAT      = 8'hFF;
   localparam logic [7:0] COL_SAT      = 8'hFF;
   localparam logic [15:0] ROW_SAT     = 16'hFFFF;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_EOF  = 2'd1;
   localparam logic [1:0] KIND_EOR  = 2'd2;
   localparam logic [1:0] KIND_OVFL = 2'd3;

   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 2;

   typedef struct packed {
      logic [7:0] separator;
      logic [7:0] quote;
      logic [7:0] header_lines;
      logic       header_load;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_value;
      logic [7:0]  column;
      logic [15:0] row;
      logic [7:0]  position;
   } result_type;

endpackage

// ----- src/csvfs_parse.sv -----
// ---------------------------------------------------------------------------
// csvfs_parse
// Input word register and parser state; decides the result for each byte.
// ---------------------------------------------------------------------------
module csvfs_parse #(
   parameter int MAX_FIELD_LEN = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  csvfs_pkg::cfg_type    cfg,
   input  logic                  out_free,
   output logic                  res_valid,
   output csvfs_pkg::result_type res
);
   import csvfs_pkg::*;

   localparam int FLEN_W = $clog2(MAX_FIELD_LEN + 1);
   localparam int WIDE_W = FLEN_W + 8;

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              adv;

   logic [7:0]        hdr_left_ff, hdr_left_in;
   logic              in_quote_ff, in_quote_in;
   logic [FLEN_W-1:0] flen_ff, flen_in;
   logic [7:0]        column_ff, column_in;
   logic [15:0]       row_ff, row_in;
   logic              halted_ff, halted_in;

   logic              emit;
   logic [1:0]        kind;
   logic [7:0]        bval;
   logic [WIDE_W-1:0] flen_wide;
   logic              is_nl;

   assign adv         = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || adv;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (adv ? 1'b0 : in_valid_ff);

   assign is_nl     = (in_byte_ff == NEWLINE_BYTE);
   assign flen_wide = WIDE_W'(flen_ff);

   always_comb begin
      hdr_left_in = hdr_left_ff;
      in_quote_in = in_quote_ff;
      flen_in     = flen_ff;
      column_in   = column_ff;
      row_in      = row_ff;
      halted_in   = halted_ff;
      emit        = 1'b0;
      kind        = KIND_DATA;
      bval        = 8'd0;
      if (in_valid_ff && !halted_ff) begin
         if (hdr_left_ff != 8'd0) begin
            if (is_nl) begin
               hdr_left_in = hdr_left_ff - 8'd1;
            end
         end else if (in_byte_ff == cfg.quote) begin
            in_quote_in = !in_quote_ff;
         end else if (!in_quote_ff && is_nl) begin
            emit      = 1'b1;
            kind      = KIND_EOR;
            column_in = 8'd0;
            row_in    = (row_ff != ROW_SAT) ? row_ff + 16'd1 : row_ff;
            flen_in   = '0;
         end else if (!in_quote_ff && in_byte_ff == cfg.separator) begin
            emit      = 1'b1;
            kind      = KIND_EOF;
            column_in = (column_ff != COL_SAT) ? column_ff + 8'd1 : column_ff;
            flen_in   = '0;
         end else if (flen_ff == FLEN_W'(MAX_FIELD_LEN)) begin
            // overflow in or out of quotes: report once, then stop
            emit      = 1'b1;
            kind      = KIND_OVFL;
            halted_in = 1'b1;
         end else begin
            emit    = 1'b1;
            kind    = KIND_DATA;
            bval    = in_byte_ff;
            flen_in = flen_ff + FLEN_W'(1);
         end
      end
   end

   assign res_valid      = adv && emit;
   assign res.kind       = kind;
   assign res.byte_value = bval;
   assign res.column     = column_ff;
   assign res.row        = row_ff;
   assign res.position   = (flen_wide > WIDE_W'(POS_SAT)) ? POS_SAT : flen_wide[7:0];

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         hdr_left_ff <= HEADER_RST;
         in_quote_ff <= 1'b0;
         flen_ff     <= '0;
         column_ff   <= 8'd0;
         row_ff      <= 16'd0;
         halted_ff   <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (cfg.header_load) begin
            hdr_left_ff <= cfg.header_lines;
         end else if (adv) begin
            hdr_left_ff <= hdr_left_in;
         end
         if (adv) begin
            in_quote_ff <= in_quote_in;
            flen_ff     <= flen_in;
            column_ff   <= column_in;
            row_ff      <= row_in;
            halted_ff   <= halted_in;
         end
      end
   end

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   a_flen_bound: assert property (@(posedge clock) disable iff (reset)
      flen_ff <= FLEN_W'(MAX_FIELD_LEN))
      else $error("field length beyond limit");

   a_ovfl_halts: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_OVFL) |=> halted_ff)
      else $error("overflow did not halt the parser");

   a_eor_clears: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_EOR) |=> (column_ff == 8'd0 && flen_ff == '0))
      else $error("end of record left column or length set");

   a_quiet_halted: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !res_valid)
      else $error("result after halt");

endmodule

// ----- src/csvfs_out.sv -----
// ---------------------------------------------------------------------------
// csvfs_out
// Result register; holds one word for the downstream side.
// ---------------------------------------------------------------------------
module csvfs_out (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    res_valid,
   input  csvfs_pkg::result_type                   res,
   output logic                                    out_free,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [csvfs_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic [csvfs_pkg::RSP_TUSER_W-1:0]       rsp_tuser
);
   import csvfs_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = res_valid ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {data_ff.position, data_ff.row, data_ff.column, data_ff.byte_value};
   assign rsp_tuser  = data_ff.kind;

endmodule

// ----- src/csv_field_splitter_top.sv -----
// ---------------------------------------------------------------------------
// csv_field_splitter_top
// Splits a delimited text stream into data bytes and field/record markers.
// ---------------------------------------------------------------------------
// Usage:
//   req_* takes one text byte per word. rsp_* gives at most one word per byte:
//   a data byte with its column, row and position, an end-of-field or
//   end-of-record marker, or a field overflow error. Header lines, quote
//   characters and bytes after an overflow give no word.
//   csr_* writes separator (index 0), quote (1) and header line count (2);
//   writing the count also reloads the header skip counter. Write only while
//   no byte is in flight.
//   The accepted byte passes the input register, then the result register,
//   before rsp_tvalid rises. One byte per cycle is sustained while rsp_tready
//   stays high; the parser state updates as each byte leaves the input register.
//   Reset (synchronous) restores the register defaults and clears all
//   counters and the halt flag. When rsp_tready is low the result word holds,
//   one more byte waits in the input register, then req_tready drops.
// ---------------------------------------------------------------------------
module csv_field_splitter_top #(
   parameter int MAX_FIELD_LEN = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [7:0] in_byte
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [7:0] byte_value, [15:8] column, [31:16] row, [39:32] position
   output logic [csvfs_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic [csvfs_pkg::RSP_TUSER_W-1:0]     rsp_tuser,   // [1:0] kind
   input  logic                                  csr_we,
   input  logic [csvfs_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [csvfs_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import csvfs_pkg::*;

   logic [7:0] separator_ff;
   logic [7:0] quote_ff;
   logic [7:0] header_ff;
   cfg_type    cfg;
   logic       out_free;
   logic       res_valid;
   result_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= SEPARATOR_RST;
         quote_ff     <= QUOTE_RST;
         header_ff    <= HEADER_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SEPARATOR: separator_ff <= csr_wdata;
            CSR_QUOTE:     quote_ff     <= csr_wdata;
            CSR_HEADER:    header_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.separator    = separator_ff;
   assign cfg.quote        = quote_ff;
   assign cfg.header_lines = csr_wdata;
   assign cfg.header_load  = csr_we && (csr_addr == CSR_HEADER) && !reset;

   csvfs_parse #(
      .MAX_FIELD_LEN (MAX_FIELD_LEN)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res        (res)
   );

   csvfs_out u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // header count register follows every write to its index
   a_hdr_written: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_addr == CSR_HEADER) |=> (header_ff == $past(csr_wdata)))
      else $error("header count write lost");

endmodule

// ----- bench/field_splitter_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// field_splitter_checker
// Watches the byte, result and register ports of the field splitter, keeps
// its own copy of the parser state, predicts the word each accepted byte
// should give and compares it with the words that come out, in order.
// ---------------------------------------------------------------------------
module field_splitter_checker #(
   parameter int MAX_FIELD_LEN = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] in_byte
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] byte_value, [15:8] column, [31:16] row, [39:32] position
   input  logic [csvfs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [csvfs_pkg::RSP_TUSER_W-1:0] rsp_tuser,   // [1:0] kind
   input  logic                              csr_we,
   input  logic [csvfs_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [csvfs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                error_count,
   output int                                pending
);
   import csvfs_pkg::*;

   logic [7:0]  sep_char   = SEPARATOR_RST;
   logic [7:0]  quote_char = QUOTE_RST;
   logic [7:0]  lines_to_skip = HEADER_RST;
   logic        quoted = 1'b0;
   logic        halted = 1'b0;
   int unsigned field_fill = 0;
   logic [7:0]  col_index = '0;
   logic [15:0] row_index = '0;
   result_type  awaited_words[$];
   int          errs = 0;

   assign error_count = errs;

   function automatic result_type make_word(input logic [1:0] k, input logic [7:0] v);
      result_type w;
      w.kind       = k;
      w.byte_value = v;
      w.column     = col_index;
      w.row        = row_index;
      w.position   = (field_fill > 255) ? POS_SAT : field_fill[7:0];
      return w;
   endfunction

   function automatic void parse_byte(input logic [7:0] b);
      if (halted) return;
      if (lines_to_skip != 0) begin
         if (b == NEWLINE_BYTE) lines_to_skip--;
         return;
      end
      // quote beats newline, newline beats separator
      if (b == quote_char) begin
         quoted = !quoted;
      end else if (!quoted && b == NEWLINE_BYTE) begin
         awaited_words.push_back(make_word(KIND_EOR, 8'h00));
         col_index  = '0;
         if (row_index != ROW_SAT) row_index++;
         field_fill = 0;
      end else if (!quoted && b == sep_char) begin
         awaited_words.push_back(make_word(KIND_EOF, 8'h00));
         if (col_index != COL_SAT) col_index++;
         field_fill = 0;
      end else if (field_fill >= MAX_FIELD_LEN) begin
         awaited_words.push_back(make_word(KIND_OVFL, 8'h00));
         halted = 1'b1;
      end else begin
         awaited_words.push_back(make_word(KIND_DATA, b));
         field_fill++;
      end
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         sep_char      = SEPARATOR_RST;
         quote_char    = QUOTE_RST;
         lines_to_skip = HEADER_RST;
         quoted        = 1'b0;
         halted        = 1'b0;
         field_fill    = 0;
         col_index     = '0;
         row_index     = '0;
         awaited_words.delete();
      end else begin
         // compare before predicting so a fresh expectation never pairs with a stray word
         if (rsp_tvalid && rsp_tready) begin
            got.kind       = rsp_tuser[1:0];
            got.byte_value = rsp_tdata[7:0];
            got.column     = rsp_tdata[15:8];
            got.row        = rsp_tdata[31:16];
            got.position   = rsp_tdata[39:32];
            if (awaited_words.size() == 0) begin
               errs++;
               $display("%0t: unexpected word kind %0d byte %02h col %0d row %0d pos %0d",
                        $time, got.kind, got.byte_value, got.column, got.row,
                        got.position);
            end else begin
               want = awaited_words.pop_front();
               if (got !== want) begin
                  errs++;
                  $display("%0t: expected %h, got %h (kind, byte, col, row, pos)",
                           $time, want, got);
               end
            end
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_SEPARATOR: sep_char = csr_wdata;
               CSR_QUOTE:     quote_char = csr_wdata;
               CSR_HEADER:    lines_to_skip = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) parse_byte(req_tdata);
      end
      pending = awaited_words.size();
   end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Feeds the field splitter delimited text: a short directed opening, then
// random records under several separator, quote and header settings, then
// saturation of column and position and a final field overflow.
// The checker beside the block judges every word.
// ---------------------------------------------------------------------------
module tb_top;
   import csvfs_pkg::*;

   localparam int FIELD_LIMIT = 256;
   localparam int PHASE_ITEMS = 100;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;     // [7:0] in_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // [7:0] byte_value, [15:8] column, [31:16] row, [39:32] position
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;     // [1:0] kind
   logic                   csr_we;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     error_count;
   int                     pending;

   // generator bookkeeping, only used to keep records well formed
   logic [7:0] cur_sep   = SEPARATOR_RST;
   logic [7:0] cur_quote = QUOTE_RST;
   logic [7:0] gen_skip  = HEADER_RST;
   logic       gen_quoted = 1'b0;
   int         gen_fill   = 0;
   int         items_sent = 0;
   int         burst_left = 0;
   int         gap_max    = 6;
   logic       hold_wanted = 1'b0;

   csv_field_splitter_top #(.MAX_FIELD_LEN(FIELD_LIMIT)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   field_splitter_checker #(.MAX_FIELD_LEN(FIELD_LIMIT)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // receiver: stall pattern switches at random between four modes
   initial begin
      int   mode;
      int   mode_left;
      logic hold_done;
      mode      = 0;
      mode_left = 0;
      hold_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_wanted && !hold_done) begin
            // long back-pressure so the block fills and drops req_tready
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_done = 1'b1;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 1) != 0);
            default: rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   task automatic send_byte(input logic [7:0] b);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (gen_skip != 0) begin
         if (b == NEWLINE_BYTE) gen_skip--;
      end else if (b == cur_quote) begin
         gen_quoted = !gen_quoted;
      end else if (!gen_quoted && (b == NEWLINE_BYTE || b == cur_sep)) begin
         gen_fill = 0;
      end else begin
         gen_fill++;
      end
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 15);
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == cur_sep || b == cur_quote || b == NEWLINE_BYTE);
      return b;
   endfunction

   // drop valid and wait until every word is out and the pipe has drained
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] sep, input logic [7:0] q,
                            input logic [7:0] hdr);
      settle();
      put_reg(CSR_SEPARATOR, sep);
      put_reg(CSR_QUOTE, q);
      put_reg(CSR_HEADER, hdr);
      put_reg(CSR_SPARE, 8'($urandom_range(0, 255)));
      csr_we    <= 1'b0;
      cur_sep   = sep;
      cur_quote = q;
      gen_skip  = hdr;
   endtask

   // leave quoted mode and end an open record whose last field is not empty
   task automatic close_record();
      if (gen_quoted) send_byte(cur_quote);
      if (gen_fill != 0) send_byte(NEWLINE_BYTE);
   endtask

   task automatic send_record();
      int         nfields;
      int         len;
      logic [7:0] b;
      close_record();
      if ($urandom_range(0, 39) == 0) begin
         repeat ($urandom_range(200, FIELD_LIMIT)) send_byte(plain_char());
         send_byte(cur_sep);
         send_byte(NEWLINE_BYTE);
      end else begin
         nfields = $urandom_range(1, 6);
         for (int f = 0; f < nfields; f++) begin
            if (f != 0) send_byte(cur_sep);
            if ($urandom_range(0, 7) == 0)
               repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            len = $urandom_range(0, 10);
            if ($urandom_range(0, 2) == 0) begin
               send_byte(cur_quote);
               repeat (len) begin
                  b = 8'($urandom_range(0, 255));
                  // a quote inside quotes goes out doubled
                  if (b == cur_quote) send_byte(b);
                  send_byte(b);
               end
               send_byte(cur_quote);
            end else begin
               repeat (len) send_byte(plain_char());
            end
         end
         if ($urandom_range(0, 15) != 0) send_byte(NEWLINE_BYTE);
      end
   endtask

   task automatic run_phase(input logic [7:0] sep, input logic [7:0] q,
                            input logic [7:0] hdr);
      int         first;
      logic [7:0] b;
      configure(sep, q, hdr);
      repeat (hdr) begin
         repeat ($urandom_range(0, (hdr > 8) ? 1 : 5)) begin
            b = 8'($urandom_range(0, 254));
            if (b >= NEWLINE_BYTE) b++;
            send_byte(b);
         end
         send_byte(NEWLINE_BYTE);
      end
      first = items_sent;
      while (items_sent - first < PHASE_ITEMS) send_record();
   endtask

   initial begin
      logic [7:0] s;
      logic [7:0] q;
      int         wait_left;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: byte extremes, empty fields, quoted separator and newline
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(cur_sep);
      send_byte(cur_quote);
      send_byte(cur_sep);
      send_byte(NEWLINE_BYTE);
      send_byte(cur_quote);
      send_byte(NEWLINE_BYTE);
      send_byte(cur_sep);
      send_byte(cur_sep);
      send_byte(NEWLINE_BYTE);

      // separator equal to newline: newline wins
      configure(NEWLINE_BYTE, 8'h00, HEADER_RST);
      send_byte(8'h61);
      send_byte(NEWLINE_BYTE);
      send_byte(8'h00);
      send_byte(NEWLINE_BYTE);
      send_byte(8'h00);

      // quote equal to newline: newline only toggles quoted mode
      configure(SEPARATOR_RST, NEWLINE_BYTE, HEADER_RST);
      send_byte(cur_sep);
      send_byte(NEWLINE_BYTE);
      send_byte(cur_sep);
      send_byte(NEWLINE_BYTE);

      // separator equal to quote: quote wins
      configure(8'hFF, 8'hFF, HEADER_RST);
      send_byte(8'hFF);
      send_byte(8'h63);
      send_byte(8'hFF);

      // two header lines, the second empty, quote and separator ignored in them
      configure(SEPARATOR_RST, QUOTE_RST, 8'd2);
      send_byte(cur_quote);
      send_byte(cur_sep);
      send_byte(NEWLINE_BYTE);
      send_byte(NEWLINE_BYTE);
      send_byte(8'h7A);
      send_byte(NEWLINE_BYTE);

      run_phase(SEPARATOR_RST, QUOTE_RST, HEADER_RST);
      run_phase(8'h00, 8'hFF, 8'd1);
      run_phase(8'hFF, 8'h00, 8'd3);
      run_phase(8'h3B, 8'h27, 8'hFF);
      repeat (2) begin
         do begin
            s = 8'($urandom_range(0, 255));
            q = 8'($urandom_range(0, 255));
         end while (s == q || s == NEWLINE_BYTE || q == NEWLINE_BYTE);
         run_phase(s, q, 8'($urandom_range(0, 5)));
      end

      // column counter runs into saturation while the receiver holds off
      configure(SEPARATOR_RST, QUOTE_RST, HEADER_RST);
      close_record();
      hold_wanted = 1'b1;
      send_byte(plain_char());
      repeat (260) send_byte(cur_sep);
      send_byte(NEWLINE_BYTE);

      // one field past the limit halts the block; later bytes give nothing
      close_record();
      repeat (FIELD_LIMIT + 1) send_byte(plain_char());
      repeat (8) send_byte(8'($urandom_range(0, 255)));

      req_tvalid <= 1'b0;
      wait_left = 20000;
      @(posedge clock);
      while (pending != 0 && wait_left > 0) begin
         @(posedge clock);
         wait_left--;
      end
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/csvfs_pkg.sv
src/csvfs_parse.sv
src/csvfs_out.sv
src/csv_field_splitter_top.sv
bench/field_splitter_checker.sv
bench/tb_top.sv
